// ===== design/mmh_pkg.sv =====
// ----------------------------------------------------------------------------
// MurmurHash64B stream hash package
// Constants and the queue entry type for the front and back parts of the
// hash unit, and the 32-bit multiply that the back part uses.
// ----------------------------------------------------------------------------
`default_nettype none

package mmh_pkg;

  localparam logic [31:0] MIX_MULT   = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT  = 24;
  localparam logic [31:0] SEED_RESET = 32'hEE6B27EB;

  localparam int unsigned FIN_SHIFT_1 = 18;
  localparam int unsigned FIN_SHIFT_2 = 22;
  localparam int unsigned FIN_SHIFT_3 = 17;
  localparam int unsigned FIN_SHIFT_4 = 19;

  // What the back part does with one word.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TAIL = 2'd1,
    KIND_FULL = 2'd2
  } kind_e;

  typedef struct packed {
    logic [31:0] word;       // tail words already masked to their valid bytes
    kind_e       kind;
    logic        first;      // word opens a message: lanes restart
    logic        last;       // word closes a message: finalize and emit
    logic [31:0] lane_init;  // seed xor stated length
    logic        mismatch;   // running byte total differs from stated length
    logic        empty;      // stated length is zero
  } entry_t;

  // Low 32 bits of a 32 by 32 product.
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction

endpackage

`default_nettype wire

// ===== design/mmh_front.sv =====
// ----------------------------------------------------------------------------
// MurmurHash64B front end
// Holds the seed, tracks message boundaries and the byte count, and turns
// each accepted word into a classified queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mmh_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_wdata_i,
  input  logic            accept_i,
  input  logic [31:0]     data_word_i,
  input  logic [2:0]      byte_count_i,
  input  logic            last_word_i,
  input  logic [31:0]     message_length_i,
  output mmh_pkg::entry_t entry_o
);
  import mmh_pkg::*;

  logic [31:0] seed_q;
  logic        in_message_q, in_message_d;
  logic [31:0] bytes_seen_q, bytes_seen_d;
  logic [31:0] stated_length_q, stated_length_d;

  logic [2:0]  count;
  logic        first;
  logic [31:0] length_eff;
  logic [31:0] bytes_base;
  logic [31:0] word_masked;
  kind_e       kind;

  // Counts of five to seven bytes behave as a full word.
  assign count      = byte_count_i[2] ? 3'd4 : byte_count_i;
  assign first      = !in_message_q;
  assign length_eff = first ? message_length_i : stated_length_q;
  assign bytes_base = first ? 32'd0 : bytes_seen_q;

  always_comb begin
    case (count)
      3'd1: word_masked = data_word_i & 32'h0000_00ff;
      3'd2: word_masked = data_word_i & 32'h0000_ffff;
      3'd3: word_masked = data_word_i & 32'h00ff_ffff;
      default: word_masked = data_word_i;
    endcase
  end

  always_comb begin
    case (count)
      3'd0: kind = KIND_NONE;
      3'd4: kind = KIND_FULL;
      default: kind = KIND_TAIL;
    endcase
  end

  assign bytes_seen_d    = bytes_base + {29'd0, count};
  assign stated_length_d = length_eff;
  assign in_message_d    = !last_word_i;

  assign entry_o.word      = word_masked;
  assign entry_o.kind      = kind;
  assign entry_o.first     = first;
  assign entry_o.last      = last_word_i;
  assign entry_o.lane_init = seed_q ^ message_length_i;
  assign entry_o.mismatch  = bytes_seen_d != length_eff;
  assign entry_o.empty     = length_eff == 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q          <= SEED_RESET;
      in_message_q    <= 1'b0;
      bytes_seen_q    <= 32'd0;
      stated_length_q <= 32'd0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        in_message_q    <= in_message_d;
        bytes_seen_q    <= bytes_seen_d;
        stated_length_q <= stated_length_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/mmh_queue.sv =====
// ----------------------------------------------------------------------------
// MurmurHash64B entry queue
// Short first-in first-out queue that decouples the front end from the
// mixing unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mmh_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mmh_pkg::entry_t entry_i,
  input  logic            pop_i,
  output mmh_pkg::entry_t head_o,
  output logic            full_o,
  output logic            nonempty_o
);
  import mmh_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign head_o     = mem_q[rd_ptr_q];
  assign full_o     = cnt_q == CntW'(Depth);
  assign nonempty_o = cnt_q != '0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/mmh_back.sv =====
// ----------------------------------------------------------------------------
// MurmurHash64B mixing unit
// Takes entries from the queue, updates the two lanes with a key multiplier
// and a lane multiplier, runs the finalization rounds and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mmh_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mmh_pkg::entry_t entry_i,
  input  logic            entry_valid_i,
  output logic            entry_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [63:0]     hash_o,
  output logic            mismatch_o
);
  import mmh_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b000_0001,
    ST_MIX  = 7'b000_0010,
    ST_FIN1 = 7'b000_0100,
    ST_FIN2 = 7'b000_1000,
    ST_FIN3 = 7'b001_0000,
    ST_FIN4 = 7'b010_0000,
    ST_OUT  = 7'b100_0000
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] lane1_q, lane1_d;
  logic [31:0] lane2_q, lane2_d;
  logic        odd_q, odd_d;
  logic [31:0] key_q, key_d;
  logic [31:0] lprod_q, lprod_d;
  logic        last_q, last_d;
  logic        mism_q, mism_d;
  logic        empty_q, empty_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_hash_q;
  logic        out_mism_q;

  logic [31:0] base1, base2;
  logic        odd_base;
  logic [31:0] key_mixed, key_op, key_prod;
  logic [31:0] lane_op, lane_prod;
  logic        out_load;

  function automatic state_e after_word(input logic last, input logic empty);
    if (!last) begin
      return ST_IDLE;
    end
    // An empty message skips finalization and reports zero.
    return empty ? ST_OUT : ST_FIN1;
  endfunction

  // A message's first word sees freshly initialized lanes.
  assign base1    = entry_i.first ? entry_i.lane_init : lane1_q;
  assign base2    = entry_i.first ? 32'd0 : lane2_q;
  assign odd_base = entry_i.first ? 1'b0 : odd_q;

  assign key_mixed = key_q ^ (key_q >> MIX_SHIFT);
  assign key_op    = (state_q == ST_IDLE) ? entry_i.word : key_mixed;
  assign key_prod  = mul32(key_op, MIX_MULT);

  always_comb begin
    case (state_q)
      ST_IDLE: begin
        if (entry_i.kind == KIND_FULL) begin
          lane_op = odd_base ? base2 : base1;
        end else begin
          lane_op = base2 ^ entry_i.word;
        end
      end
      ST_FIN1: lane_op = lane1_q ^ (lane2_q >> FIN_SHIFT_1);
      ST_FIN2: lane_op = lane2_q ^ (lane1_q >> FIN_SHIFT_2);
      ST_FIN3: lane_op = lane1_q ^ (lane2_q >> FIN_SHIFT_3);
      ST_FIN4: lane_op = lane2_q ^ (lane1_q >> FIN_SHIFT_4);
      default: lane_op = 32'd0;
    endcase
  end

  assign lane_prod = mul32(lane_op, MIX_MULT);

  assign entry_pop_o = (state_q == ST_IDLE) && entry_valid_i;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    lane1_d = lane1_q;
    lane2_d = lane2_q;
    odd_d   = odd_q;
    key_d   = key_q;
    lprod_d = lprod_q;
    last_d  = last_q;
    mism_d  = mism_q;
    empty_d = empty_q;
    case (state_q)
      ST_IDLE: begin
        if (entry_valid_i) begin
          last_d  = entry_i.last;
          mism_d  = entry_i.mismatch;
          empty_d = entry_i.empty;
          lane1_d = base1;
          lane2_d = base2;
          odd_d   = odd_base;
          case (entry_i.kind)
            KIND_FULL: begin
              key_d   = key_prod;
              lprod_d = lane_prod;
              state_d = ST_MIX;
            end
            KIND_TAIL: begin
              lane2_d = lane_prod;
              state_d = after_word(entry_i.last, entry_i.empty);
            end
            default: begin
              state_d = after_word(entry_i.last, entry_i.empty);
            end
          endcase
        end
      end
      ST_MIX: begin
        if (odd_q) begin
          lane2_d = lprod_q ^ key_prod;
        end else begin
          lane1_d = lprod_q ^ key_prod;
        end
        odd_d   = !odd_q;
        state_d = after_word(last_q, empty_q);
      end
      ST_FIN1: begin
        lane1_d = lane_prod;
        state_d = ST_FIN2;
      end
      ST_FIN2: begin
        lane2_d = lane_prod;
        state_d = ST_FIN3;
      end
      ST_FIN3: begin
        lane1_d = lane_prod;
        state_d = ST_FIN4;
      end
      ST_FIN4: begin
        lane2_d = lane_prod;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      odd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      odd_q       <= odd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lane1_q <= lane1_d;
    lane2_q <= lane2_d;
    key_q   <= key_d;
    lprod_q <= lprod_d;
    last_q  <= last_d;
    mism_q  <= mism_d;
    empty_q <= empty_d;
    if (out_load) begin
      out_hash_q <= empty_q ? 64'd0 : {lane1_q, lane2_q};
      out_mism_q <= mism_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hash_o      = out_hash_q;
  assign mismatch_o  = out_mism_q;

endmodule

`default_nettype wire

// ===== design/murmur2_64b_stream_hash.sv =====
// Flow: a full word passes the mixing unit's idle and mix states, a tail word or
//   a zero-byte word the idle state only; a last word adds 4 finalization rounds
//   (none for a zero stated length) and an output load, which waits while the
//   previous result is held. No new word is taken before the unit is idle again.
// Reset: asynchronous and active low; it empties the queue, drops the result and
//   returns the seed to 0xEE6B27EB.
// ----------------------------------------------------------------------------
// MurmurHash64B stream hash
// Hashes one message of little-endian 32-bit words and returns the 64-bit
// hash with a flag for a byte length mismatch.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur2_64b_stream_hash #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] data_word, [63:32] message_length
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] byte_count
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] hash_value
  output logic        m_axis_tuser_o    // [0] length_mismatch
);
  import mmh_pkg::*;

  entry_t front_entry;
  entry_t head_entry;
  logic   accept;
  logic   q_full;
  logic   q_nonempty;
  logic   pop;

  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  mmh_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .accept_i         (accept),
    .data_word_i      (s_axis_tdata_i[31:0]),
    .byte_count_i     (s_axis_tuser_i),
    .last_word_i      (s_axis_tlast_i),
    .message_length_i (s_axis_tdata_i[63:32]),
    .entry_o          (front_entry)
  );

  mmh_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .entry_i    (front_entry),
    .pop_i      (pop),
    .head_o     (head_entry),
    .full_o     (q_full),
    .nonempty_o (q_nonempty)
  );

  mmh_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (head_entry),
    .entry_valid_i (q_nonempty),
    .entry_pop_o   (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .hash_o        (m_axis_tdata_o),
    .mismatch_o    (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ===== design/mmh_checker.sv =====
// ----------------------------------------------------------------------------
// MurmurHash64B stream hash checker
// Port-level checks on the hash unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module mmh_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid_i,
  input wire        s_axis_tready_o,
  input wire        m_axis_tvalid_o,
  input wire        m_axis_tready_i,
  input wire [63:0] m_axis_tdata_o,
  input wire        m_axis_tuser_o
);

  // A result that is not taken stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // Leaving reset, the unit holds no result and takes words.
  assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !m_axis_tvalid_o && s_axis_tready_o)
    else $error("unit not idle after reset");

  // The queue only fills on an accepted word, so ready cannot drop without one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && !s_axis_tvalid_i |=> s_axis_tready_o)
    else $error("input ready dropped without an accepted word");

endmodule

bind murmur2_64b_stream_hash mmh_checker u_mmh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

// ===== bench/murmur2_64b_stream_hash_tb.sv =====
// ----------------------------------------------------------------------------
// MurmurHash64B stream hash testbench
// Sends whole messages, well-formed and broken, through the word stream,
// predicts the 64-bit hash and the length mismatch flag for each message in a
// local model, and checks every returned word against that prediction.
// Seeds change between phases, and each phase has its own pattern of idle
// cycles on the input and output sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module murmur2_64b_stream_hash_tb;

  import mmh_pkg::MIX_MULT;
  import mmh_pkg::MIX_SHIFT;
  import mmh_pkg::SEED_RESET;
  import mmh_pkg::FIN_SHIFT_1;
  import mmh_pkg::FIN_SHIFT_2;
  import mmh_pkg::FIN_SHIFT_3;
  import mmh_pkg::FIN_SHIFT_4;

  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PhaseWords   = 132;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
    logic [31:0] message_length;
  } msg_word_t;

  typedef struct packed {
    logic [63:0] hash_value;
    logic        length_mismatch;
  } hash_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;   // [31:0] data_word, [63:32] message_length
  logic [2:0]  s_axis_tuser_i = '0;   // [2:0] byte_count
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;        // [63:0] hash_value
  logic        m_axis_tuser_o;        // [0] length_mismatch

  murmur2_64b_stream_hash dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  msg_word_t    words_to_send[$];
  hash_result_t pending_hashes[$];

  idle_mode_e  idle_mode = IDLE_NONE;
  logic        word_taken = 1'b0;
  int unsigned calm_left = 0;
  int unsigned error_count = 0;
  int unsigned words_accepted = 0;
  int unsigned hashes_checked = 0;
  int unsigned mismatches_flagged = 0;
  int unsigned words_planned = 0;
  int unsigned stall_cycles = 0;

  // Local copy of the hash state.
  logic [31:0] seed_value = SEED_RESET;
  logic [31:0] lane_a = '0;
  logic [31:0] lane_b = '0;
  logic        to_lane_b = 1'b0;
  logic        msg_open = 1'b0;
  logic [31:0] byte_total = '0;
  logic [31:0] stated_len = '0;

  // Folds one accepted word into the lanes; a last word yields the expected hash.
  function automatic void absorb_word(input msg_word_t w);
    logic [31:0]  k;
    logic [31:0]  mask;
    logic [31:0]  h1;
    logic [31:0]  h2;
    logic [2:0]   n;
    hash_result_t r;
    n = (w.byte_count > 3'd4) ? 3'd4 : w.byte_count;
    if (!msg_open) begin
      msg_open   = 1'b1;
      stated_len = w.message_length;
      lane_a     = seed_value ^ w.message_length;
      lane_b     = '0;
      to_lane_b  = 1'b0;
      byte_total = '0;
    end
    if (n == 3'd4) begin
      k = w.data_word * MIX_MULT;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MULT;
      if (!to_lane_b) begin
        lane_a = (lane_a * MIX_MULT) ^ k;
      end else begin
        lane_b = (lane_b * MIX_MULT) ^ k;
      end
      to_lane_b = !to_lane_b;
    end else if (n != 3'd0) begin
      mask   = (32'h1 << (8 * n)) - 32'h1;
      lane_b = lane_b ^ (w.data_word & mask);
      lane_b = lane_b * MIX_MULT;
    end
    byte_total = byte_total + {29'd0, n};
    if (w.last_word) begin
      r.hash_value = '0;
      if (stated_len != 32'd0) begin
        h1 = lane_a;
        h2 = lane_b;
        h1 = h1 ^ (h2 >> FIN_SHIFT_1);
        h1 = h1 * MIX_MULT;
        h2 = h2 ^ (h1 >> FIN_SHIFT_2);
        h2 = h2 * MIX_MULT;
        h1 = h1 ^ (h2 >> FIN_SHIFT_3);
        h1 = h1 * MIX_MULT;
        h2 = h2 ^ (h1 >> FIN_SHIFT_4);
        h2 = h2 * MIX_MULT;
        r.hash_value = {h1, h2};
      end
      r.length_mismatch = (byte_total != stated_len);
      pending_hashes.push_back(r);
      msg_open = 1'b0;
    end
  endfunction

  // Drives both sides: presents the next queued word once the previous one is taken, and sets output ready.
  always @(negedge clk_i) begin
    msg_word_t   w;
    int unsigned send_pct;
    int unsigned recv_pct;
    logic        send_idle;
    if (rst_ni) begin
      send_pct = (idle_mode == IDLE_SENDER) ? 82 : (idle_mode == IDLE_BOTH) ? 6 : 0;
      recv_pct = (idle_mode == IDLE_RECEIVER) ? 82 : (idle_mode == IDLE_BOTH) ? 6 : 0;
      if (calm_left != 0) begin
        calm_left = calm_left - 1;
      end else if ($urandom_range(99) < 2) begin
        calm_left = $urandom_range(40, 10);
      end
      send_idle = (calm_left == 0) && ($urandom_range(99) < send_pct);
      m_axis_tready_i <= (calm_left != 0) || ($urandom_range(99) >= recv_pct);
      if (!s_axis_tvalid_i || word_taken) begin
        if (words_to_send.size() != 0 && !send_idle) begin
          w = words_to_send.pop_front();
          s_axis_tdata_i  <= {w.message_length, w.data_word};
          s_axis_tuser_i  <= w.byte_count;
          s_axis_tlast_i  <= w.last_word;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Output check first: a result can never stem from a word taken at the same edge.
  always @(posedge clk_i) begin
    hash_result_t want;
    msg_word_t    got_word;
    word_taken <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        hashes_checked++;
        if (m_axis_tuser_o) begin
          mismatches_flagged++;
        end
        if (pending_hashes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result hash %h mismatch %b", $time,
                   m_axis_tdata_o, m_axis_tuser_o);
        end else begin
          want = pending_hashes.pop_front();
          if (m_axis_tdata_o !== want.hash_value) begin
            error_count++;
            $display("%0t: hash_value expected %h actual %h", $time,
                     want.hash_value, m_axis_tdata_o);
          end
          if (m_axis_tuser_o !== want.length_mismatch) begin
            error_count++;
            $display("%0t: length_mismatch expected %b actual %b", $time,
                     want.length_mismatch, m_axis_tuser_o);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        got_word.data_word      = s_axis_tdata_i[31:0];
        got_word.message_length = s_axis_tdata_i[63:32];
        got_word.byte_count     = s_axis_tuser_i;
        got_word.last_word      = s_axis_tlast_i;
        absorb_word(got_word);
        words_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, StallLimit);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_word(input logic [31:0] data, input logic [2:0] count,
                           input logic last, input logic [31:0] len);
    msg_word_t w;
    w.data_word      = data;
    w.byte_count     = count;
    w.last_word      = last;
    w.message_length = len;
    words_to_send.push_back(w);
    words_planned++;
  endtask

  // Queues one message; a broken one has random byte counts and a stated
  // length that usually disagrees with what is delivered.
  task automatic plan_message(input logic well_formed);
    int unsigned nbytes;
    int unsigned nwords;
    int unsigned sent;
    int unsigned pick;
    logic [2:0]  cnt;
    logic [31:0] len;
    if (well_formed) begin
      pick = $urandom_range(15);
      nbytes = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(64, 25) : $urandom_range(24, 1);
      if (nbytes == 0) begin
        push_word($urandom, 3'd0, 1'b1, 32'd0);
      end else begin
        sent = 0;
        while (sent < nbytes) begin
          cnt = (nbytes - sent >= 4) ? 3'd4 : 3'(nbytes - sent);
          push_word($urandom, cnt, (sent + cnt == nbytes),
                    (sent == 0) ? 32'(nbytes) : $urandom);
          sent += cnt;
        end
      end
    end else begin
      nwords = $urandom_range(8, 1);
      sent = 0;
      for (int unsigned i = 0; i < nwords; i++) begin
        sent += $urandom_range(7);
      end
      pick = $urandom_range(3);
      len = (pick == 0) ? $urandom : (pick == 1) ? 32'd0 : 32'(sent + $urandom_range(6));
      for (int unsigned i = 0; i < nwords; i++) begin
        push_word($urandom, 3'($urandom_range(7)), (i == nwords - 1),
                  (i == 0) ? len : $urandom);
      end
    end
  endtask

  // Returns once every queued word is in and every hash is back, plus settling time.
  task automatic drain;
    while (words_to_send.size() != 0 || s_axis_tvalid_i || pending_hashes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    seed_value = value;
  endtask

  initial begin
    logic [31:0] phase_seed[4];
    idle_mode_e  phase_idle[4];
    phase_seed = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
    phase_idle = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed messages at the reset seed.
    push_word($urandom, 3'd0, 1'b1, 32'd0);              // empty message
    push_word(32'hFFFF_FFFF, 3'd4, 1'b1, 32'd4);
    push_word(32'h0000_0000, 3'd4, 1'b1, 32'd4);
    push_word(32'hFFFF_FFFF, 3'd1, 1'b1, 32'd1);          // upper bytes must be ignored
    push_word(32'hFFFF_FFFF, 3'd2, 1'b1, 32'd2);
    push_word(32'hFFFF_FFFF, 3'd3, 1'b1, 32'd3);
    push_word($urandom, 3'd5, 1'b1, 32'd4);               // counts above four act as four
    push_word($urandom, 3'd6, 1'b1, 32'd4);
    push_word(32'hA5A5_A5A5, 3'd7, 1'b1, 32'd4);
    // A zero-byte word and a short word in the middle of a message.
    push_word($urandom, 3'd4, 1'b0, 32'd10);
    push_word($urandom, 3'd0, 1'b0, $urandom);
    push_word($urandom, 3'd2, 1'b0, $urandom);
    push_word($urandom, 3'd4, 1'b1, $urandom);
    push_word($urandom, 3'd4, 1'b0, 32'hFFFF_FFFF);       // far too short
    push_word($urandom, 3'd4, 1'b1, $urandom);
    push_word($urandom, 3'd4, 1'b1, 32'd0);               // bytes against a zero length
    push_word(32'h8000_0000, 3'd4, 1'b0, 32'd8);
    push_word(32'h0000_0001, 3'd4, 1'b1, $urandom);
    push_word($urandom, 3'd4, 1'b0, 32'd13);
    push_word($urandom, 3'd4, 1'b0, $urandom);
    push_word($urandom, 3'd4, 1'b0, $urandom);
    push_word($urandom, 3'd1, 1'b1, $urandom);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_seed(phase_seed[p]);
      idle_mode = phase_idle[p];
      words_planned = 0;
      while (words_planned < PhaseWords) begin
        plan_message($urandom_range(9) < 8);
      end
      drain();
    end

    $display("Hashed %0d words into %0d results, %0d of them flagged for length.",
             words_accepted, hashes_checked, mismatches_flagged);
    $display("Seeds covered reset value, all zeros, all ones and random, under four idle patterns.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mmh_pkg.sv
design/mmh_front.sv
design/mmh_queue.sv
design/mmh_back.sv
design/murmur2_64b_stream_hash.sv
design/mmh_checker.sv
bench/murmur2_64b_stream_hash_tb.sv
